// ===== sv/sba_pkg.sv =====
// Shared types and constants for the segmented buffer allocator.
// Used by the controller, the datapath and the top level.
package sba_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int SEG_BITS     = 4;
    localparam int CNT_BITS     = 5;
    localparam int ACC_BITS     = 18;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_LOCATE = 2'd1;
    localparam logic [1:0] MODE_INDEX  = 2'd2;
    // Unused mode, answered as not found.
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [15:0] BLOCK_SIZE_RESET = 16'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the request and clear the walk
        logic step;      // advance the walk by one segment
        logic div_start; // start the rounding division
        logic div_step;  // one quotient bit
        logic finish;    // build the result and update the table
    } sba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done; // the walk has reached its decision
        logic div_done;  // quotient complete
        logic need_div;  // the request needs a new segment
    } sba_stat_t;

endpackage

// ===== sv/segmented_buffer_allocator_unit.sv =====
// Segmented buffer allocator: a table of up to 16 segments over one index space.
// Input stream s_* carries one request; output stream m_* carries one result.
// Write block_size (index 0) and initial_segment_size (index 1) via cfg_*
// while idle; writing index 1 rebuilds the table.
// A request is walked through the table segment by segment; a walk that runs
// off the end of the table takes a further step past the last segment. An
// allocation that finds no room while the table is not full also runs the
// bit-serial rounding division; the worst case is an append after walking 15
// segments without room. One request is in work at a time, and a new request
// can be taken in the same cycle that a result is presented.
// The result waits in an output register; while the receiver stalls a new
// request can be taken and walked, and it is held in the final state until
// the output register frees.
// Reset (aresetn, synchronous, low): empty table, block size 256.
// No clearing pass is needed: table entries beyond the count are never read.
// Depends on sba_pkg, sba_ctrl, sba_dp.
module segmented_buffer_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], alloc_size[17:2], query_index[33:18], query_segment[37:34],
    // query_offset[53:38], zero [55:54]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], result_index[17:2], found_segment[21:18],
    // found_segment_size[37:22], found_offset[53:38], new_segment[54], zero [55]
    output logic [55:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import sba_pkg::*;

    sba_cmd_t    cmd;
    sba_stat_t   stat;
    logic [1:0]  status;
    logic [15:0] result_index, found_segment_size, found_offset;
    logic [3:0]  found_segment;
    logic        new_segment;

    sba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sba_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_we             (cfg_we),
        .cfg_idx            (cfg_index),
        .cfg_data           (cfg_data),
        .in_mode            (s_tdata[1:0]),
        .in_alloc_size      (s_tdata[17:2]),
        .in_query_index     (s_tdata[33:18]),
        .in_query_segment   (s_tdata[37:34]),
        .in_query_offset    (s_tdata[53:38]),
        .status             (status),
        .result_index       (result_index),
        .found_segment      (found_segment),
        .found_segment_size (found_segment_size),
        .found_offset       (found_offset),
        .new_segment        (new_segment)
    );

    assign m_tdata = {1'b0, new_segment, found_offset, found_segment_size,
                      found_segment, result_index, status};
endmodule

// ===== sv/sba_ctrl.sv =====
// Controller state machine of the segmented buffer allocator.
// Depends on sba_pkg.
module sba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sba_pkg::sba_stat_t  stat,
    output sba_pkg::sba_cmd_t   cmd
);
    import sba_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_DIVS = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // A request is taken whenever the controller is idle; the final state
    // waits for the output register to free.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    state_next = stat.need_div ? S_DIVS : S_FIN;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (stat.div_done) begin
                    state_next = S_FIN;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_acc_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == S_IDLE)
        else $error("request accepted while busy");
    a_fin_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("conflicting datapath commands");
`endif
endmodule

// ===== sv/sba_dp.sv =====
// Datapath of the segmented buffer allocator: segment table, walk and divider.
// Depends on sba_pkg.
module sba_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  sba_pkg::sba_cmd_t   cmd,
    output sba_pkg::sba_stat_t  stat,
    input  logic                cfg_we,
    input  logic                cfg_idx,
    input  logic [15:0]         cfg_data,
    input  logic [1:0]          in_mode,
    input  logic [15:0]         in_alloc_size,
    input  logic [15:0]         in_query_index,
    input  logic [3:0]          in_query_segment,
    input  logic [15:0]         in_query_offset,
    output logic [1:0]          status,
    output logic [15:0]         result_index,
    output logic [3:0]          found_segment,
    output logic [15:0]         found_segment_size,
    output logic [15:0]         found_offset,
    output logic                new_segment
);
    import sba_pkg::*;

    // Segment table, readable by a walk pointer.
    logic [15:0] size_mem [MAX_SEGMENTS];
    logic [15:0] fill_mem [MAX_SEGMENTS];

    logic [15:0]         block_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [1:0]          mode_reg;
    logic [15:0]         req_reg, qidx_reg, qoff_reg;
    logic [SEG_BITS-1:0] qseg_reg;
    logic [CNT_BITS-1:0] ptr_reg;
    logic [ACC_BITS-1:0] first_reg;
    logic                hit_reg, done_reg;
    // Divider: quotient of (req + bs - 1) / bs, restoring, one bit a cycle.
    logic [16:0]         num_reg, rem_reg;
    logic [16:0]         quo_reg;
    logic [4:0]          dcnt_reg;
    logic [32:0]         prod;
    logic [ACC_BITS-1:0] end_idx;

    logic [SEG_BITS-1:0] ptr;
    logic [15:0]         sz, fm;
    logic                in_range;
    logic [16:0]         room;
    logic [ACC_BITS-1:0] ends;
    logic [17:0]         rtrial;
    logic [ACC_BITS-1:0] idx2;
    logic                full;

    // Result register and its next value.
    logic [1:0]          status_reg, status_next;
    logic [15:0]         index_reg, index_next;
    logic [3:0]          fseg_reg, fseg_next;
    logic [15:0]         fsize_reg, fsize_next;
    logic [15:0]         foff_reg, foff_next;
    logic                fresh_reg, fresh_next;

    assign ptr      = ptr_reg[SEG_BITS-1:0];
    assign sz       = size_mem[ptr];
    assign fm       = fill_mem[ptr];
    assign in_range = ptr_reg < count_reg;
    assign room     = {1'b0, sz} - {1'b0, fm};
    assign ends     = first_reg + ACC_BITS'(sz);
    assign rtrial   = {rem_reg, num_reg[16]} - {2'b0, block_reg};
    assign prod     = quo_reg * {1'b0, block_reg};
    assign end_idx  = first_reg + prod[ACC_BITS-1:0];
    assign idx2     = first_reg + ACC_BITS'(qoff_reg);
    assign full     = count_reg == CNT_BITS'(MAX_SEGMENTS);

    assign stat.walk_done = done_reg;
    assign stat.div_done  = dcnt_reg == 5'd17;
    assign stat.need_div  = (mode_reg == MODE_ALLOC) && !hit_reg && !full;

    // Walk: one table entry a cycle.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= in_mode;
            req_reg   <= (in_alloc_size == 16'd0) ? 16'd1 : in_alloc_size;
            qidx_reg  <= in_query_index;
            qseg_reg  <= in_query_segment;
            qoff_reg  <= in_query_offset;
            ptr_reg   <= '0;
            first_reg <= '0;
            hit_reg   <= 1'b0;
            done_reg  <= (in_mode == MODE_NONE);
        end else if (cmd.step) begin
            case (mode_reg)
                MODE_ALLOC: begin
                    if (!in_range) begin
                        done_reg <= 1'b1;
                    end else if (fm <= sz && room >= {1'b0, req_reg}) begin
                        hit_reg  <= 1'b1;
                        done_reg <= 1'b1;
                    end else begin
                        first_reg <= ends;
                        ptr_reg   <= ptr_reg + 1'b1;
                    end
                end
                MODE_LOCATE: begin
                    if (!in_range) begin
                        done_reg <= 1'b1;
                    end else if (ACC_BITS'(qidx_reg) < ends) begin
                        hit_reg  <= 1'b1;
                        done_reg <= 1'b1;
                    end else begin
                        first_reg <= ends;
                        ptr_reg   <= ptr_reg + 1'b1;
                    end
                end
                MODE_INDEX: begin
                    if ({1'b0, qseg_reg} >= count_reg) begin
                        done_reg <= 1'b1;
                    end else if (ptr == qseg_reg) begin
                        hit_reg  <= 1'b1;
                        done_reg <= 1'b1;
                    end else begin
                        first_reg <= ends;
                        ptr_reg   <= ptr_reg + 1'b1;
                    end
                end
                default: done_reg <= 1'b1;
            endcase
        end
    end

    // Rounding divider.
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            num_reg  <= {1'b0, req_reg} + {1'b0, block_reg} - 17'd1;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg  <= {num_reg[15:0], 1'b0};
            dcnt_reg <= dcnt_reg + 5'd1;
            if (!rtrial[17]) begin
                rem_reg <= rtrial[16:0];
                quo_reg <= {quo_reg[15:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[15:0], num_reg[16]};
                quo_reg <= {quo_reg[15:0], 1'b0};
            end
        end
    end

    // Configuration and table count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_reg <= BLOCK_SIZE_RESET;
            count_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_idx == 1'b0) begin
                block_reg <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
            end else begin
                count_reg <= (cfg_data != 16'd0) ? CNT_BITS'(1) : '0;
            end
        end else if (cmd.finish && stat.need_div && prod[32:16] == '0
                     && end_idx <= ACC_BITS'(18'h10000)) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // Table writes.
    always_ff @(posedge aclk) begin
        if (cfg_we && cfg_idx == 1'b1) begin
            size_mem[0] <= cfg_data;
            fill_mem[0] <= cfg_data;
        end else if (cmd.finish && mode_reg == MODE_ALLOC) begin
            if (hit_reg) begin
                fill_mem[ptr] <= fm + req_reg;
            end else if (stat.need_div && prod[32:16] == '0
                         && end_idx <= ACC_BITS'(18'h10000)) begin
                size_mem[count_reg[SEG_BITS-1:0]] <= prod[15:0];
                fill_mem[count_reg[SEG_BITS-1:0]] <= req_reg;
            end
        end
    end

    // Result selection; every field but status is zero unless status is OK.
    always_comb begin
        status_next = ST_NOTFOUND;
        index_next  = '0;
        fseg_next   = '0;
        fsize_next  = '0;
        foff_next   = '0;
        fresh_next  = 1'b0;
        case (mode_reg)
            MODE_ALLOC: begin
                if (hit_reg) begin
                    status_next = ST_OK;
                    index_next  = first_reg[15:0] + fm;
                    fseg_next   = ptr;
                    fsize_next  = sz;
                    foff_next   = fm;
                end else if (!full && prod[32:16] == '0
                             && end_idx <= ACC_BITS'(18'h10000)) begin
                    status_next = ST_OK;
                    index_next  = first_reg[15:0];
                    fseg_next   = count_reg[SEG_BITS-1:0];
                    fsize_next  = prod[15:0];
                    fresh_next  = 1'b1;
                end else begin
                    status_next = ST_FULL;
                end
            end
            MODE_LOCATE: begin
                if (hit_reg) begin
                    status_next = ST_OK;
                    index_next  = qidx_reg;
                    fseg_next   = ptr;
                    fsize_next  = sz;
                    foff_next   = qidx_reg - first_reg[15:0];
                end
            end
            MODE_INDEX: begin
                if (hit_reg) begin
                    if (idx2 >= ACC_BITS'(18'h10000)) begin
                        status_next = ST_FULL;
                    end else begin
                        status_next = ST_OK;
                        index_next  = idx2[15:0];
                        fseg_next   = qseg_reg;
                        fsize_next  = sz;
                        foff_next   = qoff_reg;
                    end
                end
            end
            default: status_next = ST_NOTFOUND;
        endcase
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            status_reg <= status_next;
            index_reg  <= index_next;
            fseg_reg   <= fseg_next;
            fsize_reg  <= fsize_next;
            foff_reg   <= foff_next;
            fresh_reg  <= fresh_next;
        end
    end

    assign status             = status_reg;
    assign result_index       = index_reg;
    assign found_segment      = fseg_reg;
    assign found_segment_size = fsize_reg;
    assign found_offset       = foff_reg;
    assign new_segment        = fresh_reg;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(MAX_SEGMENTS))
        else $error("segment count beyond table");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> dcnt_reg < 5'd17)
        else $error("divider overran");
    a_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_we && count_reg != $past(count_reg) && $past(aresetn) && !$past(cfg_we)
        |-> $past(cmd.finish))
        else $error("table grew outside an allocation");
`endif
endmodule
